// ----- sv/fsw_pkg.sv -----
// types, codes and constants shared by the flash staging word writer
// no dependencies; used by fsw_step and flash_staging_word_writer_core
package fsw_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned CfgIndexW = 2;
    localparam int unsigned PageLog2W = 5;

    localparam logic [WordW-1:0] AllOnes = 32'hFFFF_FFFF;
    localparam logic [WordW-1:0] WordBytes = 32'd4;
    localparam logic [PageLog2W-1:0] PageLog2Min = 5'd2;
    localparam logic [PageLog2W-1:0] PageLog2Max = 5'd16;
    localparam logic [PageLog2W-1:0] PageLog2Reset = 5'd12;

    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_DATA = 2'd1;
    localparam logic [1:0] CMD_END = 2'd2;
    localparam logic [1:0] CMD_ABORT = 2'd3;

    localparam logic [1:0] KIND_ERASE = 2'd0;
    localparam logic [1:0] KIND_PROGRAM = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_TOO_LARGE = 2'd1;
    localparam logic [1:0] STATUS_NOT_ACTIVE = 2'd2;

    localparam logic [CfgIndexW-1:0] REG_STORAGE_BASE = 2'd0;
    localparam logic [CfgIndexW-1:0] REG_MAX_IMAGE_SIZE = 2'd1;
    localparam logic [CfgIndexW-1:0] REG_PAGE_SIZE_LOG2 = 2'd2;

    typedef struct packed {
        logic [1:0]       command;
        logic [WordW-1:0] image_size;
        logic [7:0]       data_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [WordW-1:0] flash_address;
        logic [WordW-1:0] word_value;
        logic [1:0]       status_code;
        logic [WordW-1:0] byte_total;
        logic [WordW-1:0] image_length;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic [WordW-1:0]     storage_base;
        logic [WordW-1:0]     max_image_size;
        logic [PageLog2W-1:0] page_size_log2;
    } cfg_t;

    typedef struct packed {
        logic             session_active;
        logic [1:0]       byte_slot;
        logic [WordW-1:0] pending_word;
        logic [WordW-1:0] next_address;
        logic [WordW-1:0] accepted_bytes;
    } state_t;

    // the up to three results of one request, waiting to be sent
    typedef struct packed {
        logic             erase_pend;
        logic             prog_pend;
        logic             stat_pend;
        logic [WordW-1:0] address;
        logic [WordW-1:0] word;
        logic [1:0]       status_code;
        logic [WordW-1:0] byte_total;
        logic [WordW-1:0] image_length;
    } batch_t;

endpackage

// ----- sv/flash_staging_word_writer_core.sv -----
// top level of the flash staging word writer: registers, result sequencing, ports
// depends on fsw_pkg and fsw_step
//
// Each request (begin, data byte, end, abort) is decoded in the cycle it is taken
// and yields one to three results: an optional erase-page command, an optional
// program-word command and always a status result that carries last. Results
// leave through a single output register, one per cycle while out_ready allows.
// A request that flushes a word also yields a program-word command, preceded by
// an erase-page command when the word opens a page. The next request is taken in
// the cycle its predecessor's status result moves to the output register.
// Configuration writes take effect at once and are meant for idle periods only.
module flash_staging_word_writer_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [fsw_pkg::CfgIndexW-1:0]       cfg_index,
    input  logic [fsw_pkg::WordW-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  fsw_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output fsw_pkg::out_item_t                  out_data
);

    fsw_pkg::cfg_t      cfg_reg;
    fsw_pkg::state_t    state_reg;
    fsw_pkg::state_t    state_next;
    fsw_pkg::batch_t    batch_reg;
    fsw_pkg::batch_t    batch_next;
    fsw_pkg::batch_t    step_batch;
    fsw_pkg::out_item_t out_reg;
    fsw_pkg::out_item_t out_next;
    logic               out_valid_reg;
    logic               batch_busy;
    logic               out_load;
    logic               last_move;
    logic               in_take;

    fsw_step u_step
    (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (in_data),
        .state_next (state_next),
        .batch      (step_batch)
    );

    assign batch_busy = batch_reg.erase_pend | batch_reg.prog_pend | batch_reg.stat_pend;
    assign out_load = batch_busy && (!out_valid_reg || out_ready);
    assign last_move = out_load && !batch_reg.erase_pend && !batch_reg.prog_pend;
    assign in_ready = !batch_busy || last_move;
    assign in_take = in_valid && in_ready;

    // pick the oldest pending result of the current request
    always_comb
    begin
        out_next.kind = fsw_pkg::KIND_STATUS;
        out_next.flash_address = '0;
        out_next.word_value = '0;
        out_next.status_code = batch_reg.status_code;
        out_next.byte_total = batch_reg.byte_total;
        out_next.image_length = batch_reg.image_length;
        out_next.last = 1'b1;
        batch_next = batch_reg;
        if (batch_reg.erase_pend)
        begin
            out_next.kind = fsw_pkg::KIND_ERASE;
            out_next.flash_address = batch_reg.address;
            out_next.status_code = fsw_pkg::STATUS_OK;
            out_next.image_length = '0;
            out_next.last = 1'b0;
            batch_next.erase_pend = 1'b0;
        end
        else if (batch_reg.prog_pend)
        begin
            out_next.kind = fsw_pkg::KIND_PROGRAM;
            out_next.flash_address = batch_reg.address;
            out_next.word_value = batch_reg.word;
            out_next.status_code = fsw_pkg::STATUS_OK;
            out_next.image_length = '0;
            out_next.last = 1'b0;
            batch_next.prog_pend = 1'b0;
        end
        else
        begin
            batch_next.stat_pend = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.storage_base <= '0;
            cfg_reg.max_image_size <= '0;
            cfg_reg.page_size_log2 <= fsw_pkg::PageLog2Reset;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                fsw_pkg::REG_STORAGE_BASE:
                begin
                    cfg_reg.storage_base <= cfg_data;
                end
                fsw_pkg::REG_MAX_IMAGE_SIZE:
                begin
                    cfg_reg.max_image_size <= cfg_data;
                end
                fsw_pkg::REG_PAGE_SIZE_LOG2:
                begin
                    cfg_reg.page_size_log2 <= cfg_data[fsw_pkg::PageLog2W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.session_active <= 1'b0;
            state_reg.byte_slot <= 2'd0;
            state_reg.pending_word <= fsw_pkg::AllOnes;
            state_reg.next_address <= '0;
            state_reg.accepted_bytes <= '0;
            batch_reg.erase_pend <= 1'b0;
            batch_reg.prog_pend <= 1'b0;
            batch_reg.stat_pend <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                state_reg <= state_next;
                batch_reg <= step_batch;
            end
            else if (out_load)
            begin
                batch_reg <= batch_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

endmodule

// ----- sv/fsw_step.sv -----
// next-state and result logic for one request of the flash staging word writer
// depends on fsw_pkg
module fsw_step
(
    input  fsw_pkg::cfg_t     cfg,
    input  fsw_pkg::state_t   state,
    input  fsw_pkg::in_item_t item,
    output fsw_pkg::state_t   state_next,
    output fsw_pkg::batch_t   batch
);

    logic [fsw_pkg::PageLog2W-1:0] shift;
    logic [fsw_pkg::WordW-1:0]     page_bytes;
    logic [fsw_pkg::WordW-1:0]     page_mask;
    logic [fsw_pkg::WordW-1:0]     word_ins;
    logic [fsw_pkg::WordW-1:0]     flush_word;
    logic                          do_flush;
    logic [fsw_pkg::WordW-1:0]     addr_after;

    always_comb
    begin
        if (cfg.page_size_log2 < fsw_pkg::PageLog2Min)
        begin
            shift = fsw_pkg::PageLog2Min;
        end
        else if (cfg.page_size_log2 > fsw_pkg::PageLog2Max)
        begin
            shift = fsw_pkg::PageLog2Max;
        end
        else
        begin
            shift = cfg.page_size_log2;
        end
        page_bytes = 32'd1 << shift;
        page_mask = page_bytes - 32'd1;
    end

    always_comb
    begin
        word_ins = state.pending_word;
        word_ins[{state.byte_slot, 3'b000} +: 8] = item.data_byte;
    end

    always_comb
    begin
        state_next = state;
        do_flush = 1'b0;
        flush_word = state.pending_word;
        batch.status_code = fsw_pkg::STATUS_OK;
        batch.image_length = '0;

        case (item.command)
            fsw_pkg::CMD_BEGIN:
            begin
                if (item.image_size > cfg.max_image_size)
                begin
                    batch.status_code = fsw_pkg::STATUS_TOO_LARGE;
                end
                else
                begin
                    state_next.session_active = 1'b1;
                    state_next.byte_slot = 2'd0;
                    state_next.pending_word = fsw_pkg::AllOnes;
                    state_next.next_address = cfg.storage_base;
                    state_next.accepted_bytes = '0;
                    batch.image_length = (item.image_size & ~page_mask) + page_bytes;
                end
            end
            fsw_pkg::CMD_DATA:
            begin
                if (!state.session_active)
                begin
                    batch.status_code = fsw_pkg::STATUS_NOT_ACTIVE;
                end
                else
                begin
                    state_next.pending_word = word_ins;
                    state_next.byte_slot = state.byte_slot + 2'd1;
                    state_next.accepted_bytes = state.accepted_bytes + 32'd1;
                    flush_word = word_ins;
                    do_flush = (state.byte_slot == 2'd3);
                end
            end
            fsw_pkg::CMD_END:
            begin
                if (!state.session_active)
                begin
                    batch.status_code = fsw_pkg::STATUS_NOT_ACTIVE;
                end
                else
                begin
                    do_flush = (state.byte_slot != 2'd0);
                    state_next.session_active = 1'b0;
                end
            end
            fsw_pkg::CMD_ABORT:
            begin
                state_next.session_active = 1'b0;
                state_next.byte_slot = 2'd0;
                state_next.pending_word = fsw_pkg::AllOnes;
                state_next.next_address = '0;
                state_next.accepted_bytes = '0;
            end
            default:
            begin
                state_next = state;
            end
        endcase

        addr_after = do_flush ? state.next_address + fsw_pkg::WordBytes
                              : state.next_address;
        if (do_flush)
        begin
            state_next.next_address = addr_after;
            state_next.pending_word = fsw_pkg::AllOnes;
            state_next.byte_slot = 2'd0;
        end
        if (item.command == fsw_pkg::CMD_END && state.session_active)
        begin
            batch.image_length = addr_after - cfg.storage_base;
        end

        batch.erase_pend = do_flush && ((state.next_address & page_mask) == '0);
        batch.prog_pend = do_flush;
        batch.stat_pend = 1'b1;
        batch.address = state.next_address;
        batch.word = flush_word;
        batch.byte_total = state_next.accepted_bytes;
    end

endmodule

// ----- tb/sv/flash_staging_word_writer_core_tb.sv -----
// self-checking testbench for flash_staging_word_writer_core: a directed table, then random phases
// depends on fsw_pkg and flash_staging_word_writer_core; predicts every flash command and status
// and compares each result against it
module flash_staging_word_writer_core_tb;

    import fsw_pkg::*;

    localparam logic [CfgIndexW-1:0] REG_UNUSED = 2'd3;
    localparam int unsigned RandPhases = 6;
    localparam int unsigned PhaseItems = 56;
    localparam int unsigned SqueezePhase = 2;
    localparam int unsigned HoldCycles = 80;
    localparam int unsigned DrainTail = 8;
    localparam int unsigned IdleLimit = 2000;

    typedef struct {
        bit                   is_cfg;
        logic [CfgIndexW-1:0] reg_index;
        logic [WordW-1:0]     reg_value;
        in_item_t             req;
        bit                   typed;
        logic [1:0]           typed_status;
        logic [WordW-1:0]     typed_length;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      cfg_write_en;
    logic [CfgIndexW-1:0] cfg_index;
    logic [WordW-1:0]     cfg_data;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    cfg_t      writer_cfg;
    state_t    writer_state;
    out_item_t expected_cmds[$];
    dir_row_t  dir_rows[$];
    int        mismatches;
    int        results_seen;
    bit        tx_fast;
    bit        squeeze_req;

    flash_staging_word_writer_core u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void push_expected(logic [1:0] kind, logic [WordW-1:0] addr,
                                          logic [WordW-1:0] word, logic [1:0] status,
                                          logic [WordW-1:0] length, logic last_flag);
        out_item_t r;
        r.kind = kind;
        r.flash_address = addr;
        r.word_value = word;
        r.status_code = status;
        r.byte_total = writer_state.accepted_bytes;
        r.image_length = length;
        r.last = last_flag;
        expected_cmds.push_back(r);
    endfunction

    function automatic logic [PageLog2W-1:0] page_log2();
        logic [PageLog2W-1:0] p;
        p = writer_cfg.page_size_log2;
        if (p < PageLog2Min)
            p = PageLog2Min;
        if (p > PageLog2Max)
            p = PageLog2Max;
        return p;
    endfunction

    function automatic void program_pending_word();
        logic [WordW-1:0] mask;
        mask = (32'd1 << page_log2()) - 32'd1;
        if ((writer_state.next_address & mask) == '0)
            push_expected(KIND_ERASE, writer_state.next_address, '0, STATUS_OK, '0, 1'b0);
        push_expected(KIND_PROGRAM, writer_state.next_address, writer_state.pending_word,
                      STATUS_OK, '0, 1'b0);
        writer_state.next_address += WordBytes;
        writer_state.pending_word = AllOnes;
        writer_state.byte_slot = '0;
    endfunction

    function automatic void predict_flash_cmds(in_item_t req);
        logic [PageLog2W-1:0] p;
        logic [WordW-1:0]     length;
        case (req.command)
            CMD_BEGIN:
            begin
                if (req.image_size > writer_cfg.max_image_size)
                begin
                    push_expected(KIND_STATUS, '0, '0, STATUS_TOO_LARGE, '0, 1'b1);
                end
                else
                begin
                    p = page_log2();
                    length = ((req.image_size >> p) + 32'd1) << p;
                    writer_state.session_active = 1'b1;
                    writer_state.byte_slot = '0;
                    writer_state.pending_word = AllOnes;
                    writer_state.next_address = writer_cfg.storage_base;
                    writer_state.accepted_bytes = '0;
                    push_expected(KIND_STATUS, '0, '0, STATUS_OK, length, 1'b1);
                end
            end
            CMD_ABORT:
            begin
                writer_state.session_active = 1'b0;
                writer_state.byte_slot = '0;
                writer_state.pending_word = AllOnes;
                writer_state.next_address = '0;
                writer_state.accepted_bytes = '0;
                push_expected(KIND_STATUS, '0, '0, STATUS_OK, '0, 1'b1);
            end
            default:
            begin
                if (!writer_state.session_active)
                begin
                    push_expected(KIND_STATUS, '0, '0, STATUS_NOT_ACTIVE, '0, 1'b1);
                end
                else if (req.command == CMD_DATA)
                begin
                    writer_state.pending_word[{writer_state.byte_slot, 3'b000} +: 8] =
                        req.data_byte;
                    writer_state.byte_slot += 2'd1;
                    writer_state.accepted_bytes += 32'd1;
                    if (writer_state.byte_slot == '0)
                        program_pending_word();
                    push_expected(KIND_STATUS, '0, '0, STATUS_OK, '0, 1'b1);
                end
                else
                begin
                    if (writer_state.byte_slot != '0)
                        program_pending_word();
                    writer_state.session_active = 1'b0;
                    push_expected(KIND_STATUS, '0, '0, STATUS_OK,
                                  writer_state.next_address - writer_cfg.storage_base, 1'b1);
                end
            end
        endcase
    endfunction

    function automatic in_item_t rand_request(logic [1:0] cmd);
        in_item_t r;
        r.command = cmd;
        r.image_size = $urandom;
        r.data_byte = 8'($urandom);
        return r;
    endfunction

    function automatic void row_req(logic [1:0] cmd, logic [WordW-1:0] size, logic [7:0] b);
        dir_row_t row;
        row.is_cfg = 1'b0;
        row.reg_index = '0;
        row.reg_value = '0;
        row.req = '{command: cmd, image_size: size, data_byte: b};
        row.typed = 1'b0;
        row.typed_status = STATUS_OK;
        row.typed_length = '0;
        dir_rows.push_back(row);
    endfunction

    function automatic void row_typed(logic [1:0] cmd, logic [WordW-1:0] size, logic [7:0] b,
                                      logic [1:0] status, logic [WordW-1:0] length);
        row_req(cmd, size, b);
        dir_rows[dir_rows.size()-1].typed = 1'b1;
        dir_rows[dir_rows.size()-1].typed_status = status;
        dir_rows[dir_rows.size()-1].typed_length = length;
    endfunction

    function automatic void row_cfg(logic [CfgIndexW-1:0] idx, logic [WordW-1:0] value);
        row_req(CMD_ABORT, '0, '0);
        dir_rows[dir_rows.size()-1].is_cfg = 1'b1;
        dir_rows[dir_rows.size()-1].reg_index = idx;
        dir_rows[dir_rows.size()-1].reg_value = value;
    endfunction

    task automatic send_request(in_item_t req);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        do @(posedge clk); while (!in_ready);
        predict_flash_cmds(req);
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge clk);
        repeat (DrainTail) @(posedge clk);
    endtask

    task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [WordW-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            REG_STORAGE_BASE: writer_cfg.storage_base = value;
            REG_MAX_IMAGE_SIZE: writer_cfg.max_image_size = value;
            REG_PAGE_SIZE_LOG2: writer_cfg.page_size_log2 = value[PageLog2W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic compare_field(string name, logic [WordW-1:0] want, logic [WordW-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_flash_cmd(out_item_t got);
        out_item_t want;
        if (expected_cmds.size() == 0)
        begin
            $error("result with nothing expected: %h", got);
            mismatches++;
        end
        else
        begin
            want = expected_cmds.pop_front();
            compare_field("kind", WordW'(want.kind), WordW'(got.kind));
            compare_field("flash_address", want.flash_address, got.flash_address);
            compare_field("word_value", want.word_value, got.word_value);
            compare_field("status_code", WordW'(want.status_code), WordW'(got.status_code));
            compare_field("byte_total", want.byte_total, got.byte_total);
            compare_field("image_length", want.image_length, got.image_length);
            compare_field("last", WordW'(want.last), WordW'(got.last));
        end
    endtask

    task automatic run_random_phase(int unsigned n_items, bit squeeze);
        int unsigned sent;
        int unsigned nbytes;
        in_item_t    req;
        sent = 0;
        if (squeeze)
            squeeze_req = 1'b1;
        while (sent < n_items)
        begin
            tx_fast = squeeze || ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7)
            begin
                // well-formed session with random content
                req = rand_request(CMD_BEGIN);
                if (writer_cfg.max_image_size != AllOnes)
                    req.image_size = ($urandom_range(0, 3) == 0) ? writer_cfg.max_image_size
                                   : $urandom_range(writer_cfg.max_image_size, 0);
                send_request(req);
                nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40)
                       : $urandom_range(0, 12);
                repeat (nbytes) send_request(rand_request(CMD_DATA));
                send_request(rand_request(($urandom_range(0, 7) == 0) ? CMD_ABORT : CMD_END));
                sent += nbytes + 2;
            end
            else
            begin
                req = rand_request(2'($urandom_range(CMD_ABORT, CMD_BEGIN)));
                if (req.command == CMD_BEGIN && writer_cfg.max_image_size != AllOnes &&
                    $urandom_range(0, 1) == 1)
                    req.image_size = $urandom_range(32'hFFFF_FFFF,
                                                    writer_cfg.max_image_size + 32'd1);
                send_request(req);
                sent++;
            end
        end
    endtask

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        int unsigned stall;
        out_ready <= 1'b0;
        results_seen = 0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                stall = HoldCycles;
            end
            else
            begin
                stall = (((results_seen / 40) % 4) == 0) ? 0 : $urandom_range(0, 3);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            check_flash_cmd(out_data);
            results_seen++;
        end
    end

    initial
    begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IdleLimit)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("flash_staging_word_writer_core verification failed");
        $finish;
    end

    initial
    begin
        int unsigned max_pick;
        rst_n <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        in_data <= '0;
        mismatches = 0;
        tx_fast = 1'b0;
        squeeze_req = 1'b0;
        writer_cfg = '{storage_base: '0, max_image_size: '0, page_size_log2: PageLog2Reset};
        writer_state = '{session_active: 1'b0, byte_slot: '0, pending_word: AllOnes,
                         next_address: '0, accepted_bytes: '0};

        // reset config: base 0, max 0, 4 KiB pages
        row_typed(CMD_DATA, '0, 8'h00, STATUS_NOT_ACTIVE, '0);
        row_typed(CMD_END, '1, 8'hFF, STATUS_NOT_ACTIVE, '0);
        row_typed(CMD_BEGIN, 32'd1, 8'h00, STATUS_TOO_LARGE, '0);
        row_typed(CMD_BEGIN, '0, 8'h00, STATUS_OK, 32'h0000_1000);
        row_req(CMD_DATA, '0, 8'h77);
        row_typed(CMD_BEGIN, '0, 8'hFF, STATUS_OK, 32'h0000_1000);
        row_req(CMD_DATA, '1, 8'h00);
        row_req(CMD_DATA, '0, 8'hFF);
        row_req(CMD_DATA, '1, 8'hA5);
        row_req(CMD_DATA, '0, 8'h5A);
        row_req(CMD_END, '0, 8'h00);
        row_typed(CMD_ABORT, '1, 8'hFF, STATUS_OK, '0);
        // smallest page, top of address space
        row_cfg(REG_MAX_IMAGE_SIZE, '1);
        row_cfg(REG_PAGE_SIZE_LOG2, '0);
        row_cfg(REG_STORAGE_BASE, 32'hFFFF_FFF8);
        row_typed(CMD_BEGIN, '1, 8'h00, STATUS_OK, '0);
        row_req(CMD_DATA, '0, 8'h11);
        row_req(CMD_DATA, '0, 8'h22);
        row_req(CMD_DATA, '0, 8'h33);
        row_req(CMD_DATA, '0, 8'h44);
        row_req(CMD_DATA, '0, 8'h55);
        row_req(CMD_END, '0, 8'h00);
        // page size above range, words on both sides of a page edge
        row_cfg(REG_PAGE_SIZE_LOG2, 32'd31);
        row_cfg(REG_STORAGE_BASE, 32'h0000_FFFC);
        row_req(CMD_BEGIN, 32'h0001_2345, 8'h00);
        row_req(CMD_DATA, '0, 8'h66);
        row_req(CMD_DATA, '0, 8'h77);
        row_req(CMD_DATA, '0, 8'h88);
        row_req(CMD_DATA, '0, 8'h99);
        row_req(CMD_DATA, '0, 8'hEE);
        row_req(CMD_END, '0, 8'h00);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                go_idle();
                write_reg(dir_rows[i].reg_index, dir_rows[i].reg_value);
            end
            else
            begin
                send_request(dir_rows[i].req);
                if (dir_rows[i].typed)
                    expected_cmds[expected_cmds.size()-1] = '{kind: KIND_STATUS,
                        flash_address: '0, word_value: '0,
                        status_code: dir_rows[i].typed_status, byte_total: '0,
                        image_length: dir_rows[i].typed_length, last: 1'b1};
            end
        end

        for (int unsigned ph = 0; ph < RandPhases; ph++)
        begin
            go_idle();
            write_reg(REG_STORAGE_BASE, ($urandom_range(0, 3) == 0) ? $urandom
                                        : ($urandom & ~32'h3));
            max_pick = $urandom_range(0, 3);
            write_reg(REG_MAX_IMAGE_SIZE, (max_pick == 0) ? $urandom_range(4096, 0)
                                          : (max_pick == 1) ? $urandom : AllOnes);
            write_reg(REG_PAGE_SIZE_LOG2, ($urandom_range(0, 4) == 0) ? $urandom
                                          : $urandom_range(6, 2));
            write_reg(REG_UNUSED, $urandom);
            run_random_phase(PhaseItems, ph == SqueezePhase);
        end

        go_idle();
        if (mismatches == 0)
            $display("flash_staging_word_writer_core verification clean");
        else
            $display("flash_staging_word_writer_core verification failed");
        $finish;
    end

endmodule

// ----- flash_staging_word_writer_core.f -----
sv/fsw_pkg.sv
sv/fsw_step.sv
sv/flash_staging_word_writer_core.sv
tb/sv/flash_staging_word_writer_core_tb.sv
